[hw/rtl/tdts_pkg.sv]
// Shared types, widths and codes for the tree dependency task scheduler.
package tdts_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned TREE_W    = 2 * NODE_W + 1;
  localparam int unsigned QUEUE_W   = NODE_W + 1;

  localparam logic [1:0] CFG_LEAF_COUNT = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_GET   = 2'd2,
    OP_DONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_ACK   = 2'd0,
    STAT_ISSUE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FIN   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_DEP_RD,
    ST_DEP_WA,
    ST_DEP_WB,
    ST_PAR_RD,
    ST_PAR_WA,
    ST_PAR_WB,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_GET_OUT,
    ST_DONE_RD,
    ST_DONE_WR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
  } item_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } ctrl_t;

endpackage

[hw/rtl/tree_dependency_task_scheduler_core.sv]
// Top level of the tree dependency task scheduler: config registers, front and back end.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | action, node_index, left/right_child, is_leaf
//   out     | output    | out_valid_o/out_ready_i | status, task_*, sackin_total
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Get runs a linear scan of the queue store through its single read port unless the tree is
// finished. Start runs a clearing sweep, then depth, parent and leaf passes. After reset a
// clearing sweep runs with in_ready_o low; config beats are taken throughout. A two-beat
// queue between front and back end keeps input taken while a result waits on out_ready_i.
module tree_dependency_task_scheduler_core import tdts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [NODE_W-1:0] node_index_i,
  input  logic [NODE_W-1:0] left_child_i,
  input  logic [NODE_W-1:0] right_child_i,
  input  logic              is_leaf_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [NODE_W-1:0] task_node_o,
  output logic              task_is_leaf_o,
  output logic [NODE_W-1:0] task_left_o,
  output logic [NODE_W-1:0] task_right_o,
  output logic [SUM_W-1:0]  sackin_total_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [NODE_W-1:0] cfg_data_i
);

  logic [NODE_W-1:0] leaf_count_q, node_count_q;
  logic              head_valid;
  item_t             head;
  ctrl_t             ctrl;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= NODE_W'(1);
      node_count_q <= NODE_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LEAF_COUNT) begin
        leaf_count_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_NODE_COUNT) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  tdts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .action_i, .node_index_i, .left_child_i, .right_child_i, .is_leaf_i,
    .head_valid_o(head_valid), .head_o(head), .ctrl_i(ctrl)
  );

  tdts_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid), .head_i(head), .ctrl_o(ctrl),
    .leaf_count_i(leaf_count_q), .node_count_i(node_count_q),
    .out_valid_o, .out_ready_i,
    .status_o, .task_node_o, .task_is_leaf_o, .task_left_o, .task_right_o,
    .sackin_total_o
  );

`ifndef NO_ASSERTIONS
  a_fin_no_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FIN) |-> (task_node_o == '0) && !task_is_leaf_o)
    else $error("finished beat carries task fields");
  a_sum_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sackin_total_o != '0) |-> (status_o == STAT_ACK))
    else $error("sackin total on a non-acknowledge beat");
  a_leaf_no_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && task_is_leaf_o |-> (task_left_o == '0) && (task_right_o == '0))
    else $error("issued leaf carries children");
  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.init_busy |-> !in_ready_o && !head_valid)
    else $error("item taken during clearing sweep");
`endif

endmodule

[hw/rtl/tdts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tdts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tdts_front.sv]
// Front end: accepts input beats, decodes the action and queues them for the back end.
module tdts_front import tdts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [NODE_W-1:0] node_index_i,
  input  logic [NODE_W-1:0] left_child_i,
  input  logic [NODE_W-1:0] right_child_i,
  input  logic              is_leaf_i,
  output logic              head_valid_o,
  output item_t             head_o,
  input  ctrl_t             ctrl_i
);

  item_t      fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  item_t      item;
  logic       push;

  // decode the action code
  always_comb begin
    item       = '0;
    item.node  = node_index_i;
    item.left  = left_child_i;
    item.right = right_child_i;
    item.leaf  = is_leaf_i;
    unique case (action_i)
      2'd0:    item.op = OP_LOAD;
      2'd1:    item.op = OP_START;
      2'd2:    item.op = OP_GET;
      default: item.op = OP_DONE;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2) && !ctrl_i.init_busy;
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rptr_q];

  // store beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= item;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (ctrl_i.pop) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, ctrl_i.pop};
    end
  end

endmodule

[hw/rtl/tdts_back.sv]
// Back end: sequencer over the node stores that carries out load, start, get and done.
module tdts_back import tdts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  item_t             head_i,
  output ctrl_t             ctrl_o,
  input  logic [NODE_W-1:0] leaf_count_i,
  input  logic [NODE_W-1:0] node_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [NODE_W-1:0] task_node_o,
  output logic              task_is_leaf_o,
  output logic [NODE_W-1:0] task_left_o,
  output logic [NODE_W-1:0] task_right_o,
  output logic [SUM_W-1:0]  sackin_total_o
);

  state_e state_q, state_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic [NODE_W-1:0] dval_q, dval_d;
  logic [NODE_W-1:0] bch_q, bch_d;
  logic              leafm_q, leafm_d;
  logic [NODE_W-1:0] par_q, par_d;
  logic              found_q, found_d;
  logic [NODE_W-1:0] best_q, best_d;
  logic [NODE_W-1:0] bkey_q, bkey_d;
  logic              rd_v_q, rd_v_d;
  logic [NODE_W-1:0] rd_idx_q, rd_idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              fin_q, fin_d;
  logic [CNT_W-1:0]  rdy0_q, rdy0_d;

  status_e           res_stat_q, res_stat_d;
  logic [NODE_W-1:0] res_node_q, res_node_d;
  logic              res_leaf_q, res_leaf_d;
  logic [NODE_W-1:0] res_left_q, res_left_d;
  logic [NODE_W-1:0] res_right_q, res_right_d;
  logic [SUM_W-1:0]  res_sum_q, res_sum_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_stat_q;
  logic [NODE_W-1:0] out_node_q, out_left_q, out_right_q;
  logic              out_leaf_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_load;

  // store ports
  logic               tree_we;
  logic [NODE_W-1:0]  tree_wa, tree_ra;
  logic [TREE_W-1:0]  tree_wd, tree_rd;
  logic               dep_we;
  logic [NODE_W-1:0]  dep_wa, dep_ra, dep_wd, dep_rd;
  logic               par_we;
  logic [NODE_W-1:0]  par_wa, par_ra, par_wd, par_rd;
  logic               rdy_we;
  logic [NODE_W-1:0]  rdy_wa, rdy_ra;
  logic [CNT_W-1:0]   rdy_wd, rdy_rd;
  logic               q_we;
  logic [NODE_W-1:0]  q_wa, q_ra;
  logic [QUEUE_W-1:0] q_wd, q_rd;

  logic [NODE_W-1:0] depth_next;
  logic [CNT_W-1:0]  rdy_next;
  logic              take;

  tdts_ram #(.WIDTH(TREE_W), .DEPTH(MAX_NODES)) u_tree_ram (
    .clk_i, .we_i(tree_we), .waddr_i(tree_wa), .wdata_i(tree_wd),
    .raddr_i(tree_ra), .rdata_o(tree_rd)
  );
  tdts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth_ram (
    .clk_i, .we_i(dep_we), .waddr_i(dep_wa), .wdata_i(dep_wd),
    .raddr_i(dep_ra), .rdata_o(dep_rd)
  );
  tdts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i, .we_i(par_we), .waddr_i(par_wa), .wdata_i(par_wd),
    .raddr_i(par_ra), .rdata_o(par_rd)
  );
  tdts_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_ready_ram (
    .clk_i, .we_i(rdy_we), .waddr_i(rdy_wa), .wdata_i(rdy_wd),
    .raddr_i(rdy_ra), .rdata_o(rdy_rd)
  );
  tdts_ram #(.WIDTH(QUEUE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .raddr_i(q_ra), .rdata_o(q_rd)
  );

  assign depth_next = dep_rd + 1'b1;
  assign rdy_next   = rdy_rd + 1'b1;
  // queue entry from the previous scan read wins on valid and key at or above best
  assign take = rd_v_q && q_rd[NODE_W] && (!found_q || (q_rd[NODE_W-1:0] >= bkey_q));
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // sequencer: next state, store ports and result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dval_d      = dval_q;
    bch_d       = bch_q;
    leafm_d     = leafm_q;
    par_d       = par_q;
    found_d     = found_q;
    best_d      = best_q;
    bkey_d      = bkey_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = cnt_q;
    sum_d       = sum_q;
    fin_d       = fin_q;
    rdy0_d      = rdy0_q;
    res_stat_d  = res_stat_q;
    res_node_d  = res_node_q;
    res_leaf_d  = res_leaf_q;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_sum_d   = res_sum_q;
    ctrl_o      = '0;

    tree_we = 1'b0;
    tree_wa = head_i.node;
    tree_wd = {head_i.leaf, head_i.left, head_i.right};
    tree_ra = cnt_q;
    dep_we  = 1'b0;
    dep_wa  = cnt_q;
    dep_wd  = '0;
    dep_ra  = cnt_q;
    par_we  = 1'b0;
    par_wa  = cnt_q;
    par_wd  = '0;
    par_ra  = cnt_q;
    rdy_we  = 1'b0;
    rdy_wa  = cnt_q;
    rdy_wd  = '0;
    rdy_ra  = cnt_q;
    q_we    = 1'b0;
    q_wa    = cnt_q;
    q_wd    = '0;
    q_ra    = cnt_q;

    if (take) begin
      found_d = 1'b1;
      best_d  = rd_idx_q;
      bkey_d  = q_rd[NODE_W-1:0];
    end

    ctrl_o.init_busy = (state_q == ST_INIT);

    unique case (state_q)
      ST_INIT, ST_CLR: begin
        dep_we = 1'b1;
        par_we = 1'b1;
        rdy_we = 1'b1;
        q_we   = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == NODE_W'(MAX_NODES - 1)) begin
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else if (node_count_i > leaf_count_i) begin
            cnt_d   = node_count_i - 1'b1;
            state_d = ST_DEP_RD;
          end else if (node_count_i != '0) begin
            cnt_d   = '0;
            state_d = ST_PAR_RD;
          end else if (leaf_count_i != '0) begin
            cnt_d   = '0;
            state_d = ST_LEAF_RD;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end

      ST_IDLE: begin
        res_stat_d  = STAT_ACK;
        res_node_d  = '0;
        res_leaf_d  = 1'b0;
        res_left_d  = '0;
        res_right_d = '0;
        res_sum_d   = '0;
        dep_ra      = head_i.node;
        par_ra      = head_i.node;
        if (head_valid_i) begin
          unique case (head_i.op)
            OP_LOAD: begin
              tree_we = 1'b1;
              state_d = ST_RESULT;
            end
            OP_START: begin
              cnt_d   = '0;
              sum_d   = '0;
              fin_d   = 1'b0;
              rdy0_d  = '0;
              state_d = ST_CLR;
            end
            OP_GET: begin
              if (fin_q) begin
                res_stat_d = STAT_FIN;
                state_d    = ST_RESULT;
              end else begin
                cnt_d   = '0;
                found_d = 1'b0;
                bkey_d  = '0;
                best_d  = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_DONE_RD;
            end
          endcase
        end
      end

      // depth pass, root downward
      ST_DEP_RD: begin
        state_d = ST_DEP_WA;
      end
      ST_DEP_WA: begin
        dep_we  = !tree_rd[TREE_W-1];
        dep_wa  = tree_rd[2*NODE_W-1:NODE_W];
        dep_wd  = depth_next;
        dval_d  = depth_next;
        bch_d   = tree_rd[NODE_W-1:0];
        leafm_d = tree_rd[TREE_W-1];
        state_d = ST_DEP_WB;
      end
      ST_DEP_WB: begin
        dep_we = !leafm_q;
        dep_wa = bch_q;
        dep_wd = dval_q;
        if (cnt_q == leaf_count_i) begin
          cnt_d   = '0;
          state_d = ST_PAR_RD;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_DEP_RD;
        end
      end

      // parent pass, node zero upward
      ST_PAR_RD: begin
        state_d = ST_PAR_WA;
      end
      ST_PAR_WA: begin
        par_we  = !tree_rd[TREE_W-1];
        par_wa  = tree_rd[2*NODE_W-1:NODE_W];
        par_wd  = cnt_q;
        bch_d   = tree_rd[NODE_W-1:0];
        leafm_d = tree_rd[TREE_W-1];
        state_d = ST_PAR_WB;
      end
      ST_PAR_WB: begin
        par_we = !leafm_q;
        par_wa = bch_q;
        par_wd = cnt_q;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == node_count_i - 1'b1) begin
          cnt_d = '0;
          if (leaf_count_i != '0) begin
            state_d = ST_LEAF_RD;
          end else begin
            state_d = ST_RESULT;
          end
        end else begin
          state_d = ST_PAR_RD;
        end
      end

      // queue leaves and sum depths
      ST_LEAF_RD: begin
        state_d = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        q_we  = 1'b1;
        q_wd  = {1'b1, dep_rd};
        sum_d = sum_q + SUM_W'(dep_rd) + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == leaf_count_i - 1'b1) begin
          res_sum_d = sum_q + SUM_W'(dep_rd) + 1'b1;
          state_d   = ST_RESULT;
        end else begin
          state_d = ST_LEAF_RD;
        end
      end

      // linear scan for the deepest ready node
      ST_SCAN: begin
        rd_v_d = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == NODE_W'(MAX_NODES - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (!found_d) begin
          res_stat_d = STAT_EMPTY;
          state_d    = ST_RESULT;
        end else begin
          q_we    = 1'b1;
          q_wa    = best_d;
          q_wd    = '0;
          tree_ra = best_d;
          state_d = ST_GET_OUT;
        end
      end
      ST_GET_OUT: begin
        res_stat_d = STAT_ISSUE;
        res_node_d = best_q;
        res_leaf_d = tree_rd[TREE_W-1];
        if (!tree_rd[TREE_W-1]) begin
          res_left_d  = tree_rd[2*NODE_W-1:NODE_W];
          res_right_d = tree_rd[NODE_W-1:0];
        end
        state_d = ST_RESULT;
      end

      // count a finished child
      ST_DONE_RD: begin
        par_d   = par_rd;
        dval_d  = dep_rd;
        rdy_ra  = par_rd;
        state_d = ST_DONE_WR;
      end
      ST_DONE_WR: begin
        rdy_we = 1'b1;
        rdy_wa = par_q;
        rdy_wd = rdy_next;
        if (rdy_next == CNT_W'(2)) begin
          q_we = 1'b1;
          q_wa = par_q;
          q_wd = {1'b1, dval_q};
        end
        if (par_q == '0) begin
          rdy0_d = rdy_next;
        end
        if (((par_q == '0) ? rdy_next : rdy0_q) == CNT_W'(1)) begin
          fin_d = 1'b1;
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_load) begin
          ctrl_o.pop = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold the output beat until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      found_q     <= 1'b0;
      fin_q       <= 1'b0;
      rdy0_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      found_q     <= found_d;
      fin_q       <= fin_d;
      rdy0_q      <= rdy0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dval_q      <= dval_d;
    bch_q       <= bch_d;
    leafm_q     <= leafm_d;
    par_q       <= par_d;
    best_q      <= best_d;
    bkey_q      <= bkey_d;
    rd_idx_q    <= rd_idx_d;
    sum_q       <= sum_d;
    res_stat_q  <= res_stat_d;
    res_node_q  <= res_node_d;
    res_leaf_q  <= res_leaf_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_sum_q   <= res_sum_d;
    if (out_load) begin
      out_stat_q  <= res_stat_q;
      out_node_q  <= res_node_q;
      out_leaf_q  <= res_leaf_q;
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
      out_sum_q   <= res_sum_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign task_node_o    = out_node_q;
  assign task_is_leaf_o = out_leaf_q;
  assign task_left_o    = out_left_q;
  assign task_right_o   = out_right_q;
  assign sackin_total_o = out_sum_q;

endmodule
